[hw/rtl/vsc_pkg.sv]
// shared types and constants for the voltage stabilizer controller
// no dependencies; used by vsc_in_if and every rtl module
package vsc_pkg;

  localparam int CFG_W           = 10;
  localparam int SAMPLE_BITS_DEF = 10;
  localparam int APB_AW          = 5;
  localparam int APB_DW          = 32;
  localparam int REG_IDX_W       = 3;

  localparam logic [CFG_W-1:0] ERR_MAX = 10'd1023;

  // register index codes
  localparam logic [REG_IDX_W-1:0] REG_TRIP_LOW  = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_TRIP_HIGH = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_BAND_LOW  = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_BAND_HIGH = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_TRIP_HOLD = 3'd4;

  // register reset values
  localparam logic [CFG_W-1:0] TRIP_LOW_RST  = 10'd140;
  localparam logic [CFG_W-1:0] TRIP_HIGH_RST = 10'd290;
  localparam logic [CFG_W-1:0] BAND_LOW_RST  = 10'd200;
  localparam logic [CFG_W-1:0] BAND_HIGH_RST = 10'd240;
  localparam logic [CFG_W-1:0] TRIP_HOLD_RST = 10'd20;

  typedef struct packed {
    logic [CFG_W-1:0] trip_low;
    logic [CFG_W-1:0] trip_high;
    logic [CFG_W-1:0] band_low;
    logic [CFG_W-1:0] band_high;
    logic [CFG_W-1:0] trip_hold_ticks;
  } cfg_t;

endpackage

[hw/rtl/vsc_in_if.sv]
// request channel into the controller: tick or converter sample
// depends on vsc_pkg for the default sample width
interface vsc_in_if #(
  parameter int SAMPLE_BITS = vsc_pkg::SAMPLE_BITS_DEF
);
  logic                   valid;
  logic                   ready;
  logic                   kind;
  logic [SAMPLE_BITS-1:0] sample_value;

  modport source (output valid, output kind, output sample_value, input ready);
  modport sink   (input valid, input kind, input sample_value, output ready);
endinterface

[hw/rtl/vsc_out_if.sv]
// result channel out of the controller: relay and transistor drive bits
// no package dependencies
interface vsc_out_if;
  logic valid;
  logic ready;
  logic transistor_on;
  logic circuit_on;
  logic coil_reverse;
  logic sample_request;
  logic sample_taken;

  modport source (output valid, output transistor_on, output circuit_on,
                  output coil_reverse, output sample_request, output sample_taken,
                  input ready);
  modport sink   (input valid, input transistor_on, input circuit_on,
                  input coil_reverse, input sample_request, input sample_taken,
                  output ready);
endinterface

[hw/rtl/vsc_cfg.sv]
// apb register file holding the trip limits, band edges and trip hold time
// depends on vsc_pkg for register codes, reset values and cfg_t
module vsc_cfg (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [vsc_pkg::APB_AW-1:0]   paddr,
  input  logic [vsc_pkg::APB_DW-1:0]   pwdata,
  output logic [vsc_pkg::APB_DW-1:0]   prdata,
  output logic                         pready,
  output vsc_pkg::cfg_t                cfg
);

  vsc_pkg::cfg_t                   cfg_r;
  logic                            wr_en;
  logic [vsc_pkg::REG_IDX_W-1:0]   idx;
  logic [vsc_pkg::CFG_W-1:0]       wval;
  logic [vsc_pkg::CFG_W-1:0]       rval;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = paddr[vsc_pkg::APB_AW-1:2];
  assign wval   = pwdata[vsc_pkg::CFG_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.trip_low        <= vsc_pkg::TRIP_LOW_RST;
      cfg_r.trip_high       <= vsc_pkg::TRIP_HIGH_RST;
      cfg_r.band_low        <= vsc_pkg::BAND_LOW_RST;
      cfg_r.band_high       <= vsc_pkg::BAND_HIGH_RST;
      cfg_r.trip_hold_ticks <= vsc_pkg::TRIP_HOLD_RST;
    end else if (wr_en) begin
      unique case (idx)
        vsc_pkg::REG_TRIP_LOW:  cfg_r.trip_low        <= wval;
        vsc_pkg::REG_TRIP_HIGH: cfg_r.trip_high       <= wval;
        vsc_pkg::REG_BAND_LOW:  cfg_r.band_low        <= wval;
        vsc_pkg::REG_BAND_HIGH: cfg_r.band_high       <= wval;
        vsc_pkg::REG_TRIP_HOLD: cfg_r.trip_hold_ticks <= wval;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      vsc_pkg::REG_TRIP_LOW:  rval = cfg_r.trip_low;
      vsc_pkg::REG_TRIP_HIGH: rval = cfg_r.trip_high;
      vsc_pkg::REG_BAND_LOW:  rval = cfg_r.band_low;
      vsc_pkg::REG_BAND_HIGH: rval = cfg_r.band_high;
      vsc_pkg::REG_TRIP_HOLD: rval = cfg_r.trip_hold_ticks;
      default:                rval = '0;
    endcase
  end

  assign prdata = {{(vsc_pkg::APB_DW - vsc_pkg::CFG_W){1'b0}}, rval};
  assign cfg    = cfg_r;

endmodule

[hw/rtl/vsc_core.sv]
// request register, one-step regulation logic, controller state and result register
// depends on vsc_pkg (cfg_t, widths) and the vsc_in_if / vsc_out_if channels
module vsc_core #(
  parameter int SAMPLE_BITS = vsc_pkg::SAMPLE_BITS_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  vsc_pkg::cfg_t cfg,
  vsc_in_if.sink        in_ch,
  vsc_out_if.source     out_ch
);

  localparam int CW = (SAMPLE_BITS > vsc_pkg::CFG_W) ? SAMPLE_BITS : vsc_pkg::CFG_W;
  localparam int NW = vsc_pkg::CFG_W;

  // pipeline control
  logic                   in_v_r;
  logic                   out_v_r;
  logic                   adv;
  logic                   step;
  logic                   in_fire;

  // request register
  logic                   kind_r;
  logic [SAMPLE_BITS-1:0] sample_r;

  // controller state
  logic [NW-1:0] countdown_r,   countdown_nxt;
  logic          switch_on_r,   switch_on_nxt;
  logic          breaker_r,     breaker_nxt;
  logic [NW-1:0] err_r,         err_nxt;
  logic          load_r,        load_nxt;
  logic          coil_r,        coil_nxt;
  logic          taken_nxt;

  // result register
  logic          res_ton_r, res_con_r, res_coil_r, res_req_r, res_taken_r;

  logic          req_cur;
  logic [CW-1:0] v_ext, trip_lo, trip_hi, band_lo, band_hi;
  logic [CW-1:0] diff_lo, diff_hi;
  logic [NW-1:0] err_lo, err_hi;

  assign adv         = !out_v_r || out_ch.ready;
  assign step        = in_v_r && adv;
  assign in_ch.ready = !in_v_r || adv;
  assign in_fire     = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (in_fire) begin
        in_v_r <= 1'b1;
      end else if (step) begin
        in_v_r <= 1'b0;
      end
      if (step) begin
        out_v_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      kind_r   <= in_ch.kind;
      sample_r <= in_ch.sample_value;
    end
  end

  assign req_cur = (countdown_r == '0) && switch_on_r;
  assign v_ext   = CW'(sample_r);
  assign trip_lo = CW'(cfg.trip_low);
  assign trip_hi = CW'(cfg.trip_high);
  assign band_lo = CW'(cfg.band_low);
  assign band_hi = CW'(cfg.band_high);
  assign diff_lo = band_lo - v_ext;
  assign diff_hi = v_ext - band_hi;
  // errors saturate to the counter width
  assign err_lo  = (diff_lo > CW'(vsc_pkg::ERR_MAX)) ? vsc_pkg::ERR_MAX : diff_lo[NW-1:0];
  assign err_hi  = (diff_hi > CW'(vsc_pkg::ERR_MAX)) ? vsc_pkg::ERR_MAX : diff_hi[NW-1:0];

  always_comb begin
    countdown_nxt = countdown_r;
    switch_on_nxt = switch_on_r;
    breaker_nxt   = breaker_r;
    err_nxt       = err_r;
    load_nxt      = load_r;
    coil_nxt      = coil_r;
    taken_nxt     = 1'b0;
    if (!kind_r) begin
      if (countdown_r != '0) begin
        countdown_nxt = countdown_r - NW'(1);
      end
    end else if (req_cur) begin
      taken_nxt = 1'b1;
      // tests applied in order, later ones see earlier updates
      if (v_ext > trip_hi || v_ext < trip_lo) begin
        load_nxt      = 1'b0;
        countdown_nxt = cfg.trip_hold_ticks;
        breaker_nxt   = 1'b1;
      end
      if (v_ext >= band_lo && v_ext <= band_hi) begin
        load_nxt      = 1'b1;
        breaker_nxt   = 1'b0;
        countdown_nxt = err_r;
        switch_on_nxt = 1'b0;
      end
      if (v_ext < band_lo && !breaker_nxt) begin
        err_nxt       = err_lo;
        countdown_nxt = err_lo;
        coil_nxt      = 1'b0;
        switch_on_nxt = 1'b0;
      end
      if (v_ext > band_hi && !breaker_nxt) begin
        err_nxt       = err_hi;
        countdown_nxt = err_hi;
        coil_nxt      = 1'b1;
        switch_on_nxt = 1'b0;
      end
    end
    // off time over: switch back on for the on phase
    if (countdown_nxt == '0 && !switch_on_nxt) begin
      switch_on_nxt = 1'b1;
      countdown_nxt = err_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      countdown_r <= '0;
      switch_on_r <= 1'b1;
      breaker_r   <= 1'b1;
      err_r       <= '0;
      load_r      <= 1'b0;
      coil_r      <= 1'b0;
    end else if (step) begin
      countdown_r <= countdown_nxt;
      switch_on_r <= switch_on_nxt;
      breaker_r   <= breaker_nxt;
      err_r       <= err_nxt;
      load_r      <= load_nxt;
      coil_r      <= coil_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      res_ton_r   <= switch_on_nxt;
      res_con_r   <= load_nxt;
      res_coil_r  <= coil_nxt;
      res_req_r   <= (countdown_nxt == '0) && switch_on_nxt;
      res_taken_r <= taken_nxt;
    end
  end

  assign out_ch.valid          = out_v_r;
  assign out_ch.transistor_on  = res_ton_r;
  assign out_ch.circuit_on     = res_con_r;
  assign out_ch.coil_reverse   = res_coil_r;
  assign out_ch.sample_request = res_req_r;
  assign out_ch.sample_taken   = res_taken_r;

`ifndef SYNTHESIS
  // the transistor is never left off with an expired countdown
  a_off_has_time: assert property (@(posedge clk) disable iff (!rst_n)
    !switch_on_r |-> countdown_r != '0)
    else $error("transistor off with zero countdown");

  // breaker and load relay always agree
  a_relay_agree: assert property (@(posedge clk) disable iff (!rst_n)
    load_r == !breaker_r)
    else $error("load relay disagrees with breaker state");

  // an unrequested sample changes nothing
  a_ignored_sample: assert property (@(posedge clk) disable iff (!rst_n)
    step && kind_r && !req_cur |=>
      $stable(countdown_r) && $stable(switch_on_r) && $stable(err_r) && $stable(breaker_r))
    else $error("unrequested sample changed state");

  // a tick counts a countdown above one down by one
  a_tick_dec: assert property (@(posedge clk) disable iff (!rst_n)
    step && !kind_r && countdown_r > NW'(1) |=> countdown_r == $past(countdown_r) - NW'(1))
    else $error("tick did not decrement countdown");
`endif

endmodule

[hw/rtl/voltage_stabilizer_controller.sv]
// top level of the mains voltage guard and stabilizer
// depends on vsc_pkg, vsc_in_if, vsc_out_if, vsc_cfg and vsc_core
//
// Takes one request per clock cycle unless stalled, either a one millisecond
// tick or a converter sample, and returns exactly one result per request:
// the request sits in the request register, then the regulation logic
// fills the result register. A result that waits holds the request behind it
// in the request register, so the input stalls only once both registers are
// full; with the result side ready the block sustains one request per cycle.
// Samples are only used while sample_request is set; otherwise they come
// back with sample_taken low. The user must write registers over the apb
// port only while no request is in flight (not enforced by the block); they
// take effect on the next request; there is no start-up sweep after reset.
module voltage_stabilizer_controller #(
  parameter int SAMPLE_BITS = vsc_pkg::SAMPLE_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  vsc_in_if.sink                     in_ch,
  vsc_out_if.source                  out_ch,
  input  logic                       cfg_psel,
  input  logic                       cfg_penable,
  input  logic                       cfg_pwrite,
  input  logic [vsc_pkg::APB_AW-1:0] cfg_paddr,
  input  logic [vsc_pkg::APB_DW-1:0] cfg_pwdata,
  output logic [vsc_pkg::APB_DW-1:0] cfg_prdata,
  output logic                       cfg_pready
);

  vsc_pkg::cfg_t cfg;

  vsc_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .cfg     (cfg)
  );

  vsc_core #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg    (cfg),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

endmodule
